// File: hw/rtl/tlqs_pkg.sv
package tlqs_pkg;

   // Fixed field widths of the request, the response and the register port.
   localparam int ID_W        = 8;
   localparam int PRIO_W      = 4;
   localparam int BURST_IN_W  = 16;
   localparam int STATUS_W    = 3;
   localparam int CLASS_W     = 2;
   localparam int COUNT_OUT_W = 5;
   localparam int CTR_W       = 32;
   localparam int QUANTUM_W   = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;

   // Request modes.
   localparam logic MODE_ARRIVE = 1'b0;
   localparam logic MODE_TICK   = 1'b1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_QUEUED_FORE = 3'd0;
   localparam logic [STATUS_W-1:0] ST_QUEUED_BACK = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DROP_ZERO   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DROP_FULL   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_TICK_DONE   = 3'd4;

   // Class that ran on a tick.
   localparam logic [CLASS_W-1:0] CLS_IDLE = 2'd0;
   localparam logic [CLASS_W-1:0] CLS_FORE = 2'd1;
   localparam logic [CLASS_W-1:0] CLS_BACK = 2'd2;

   // Register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FG_LIMIT = 2'd1;
   localparam logic [QUANTUM_W-1:0] QUANTUM_RESET  = 8'd5;
   localparam logic [PRIO_W-1:0]    FG_LIMIT_RESET = 4'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic arrive;
      logic idle_tick;
      logic read_head;
      logic rotate;
      logic serve;
   } tlqs_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic mode_tick;
      logic fore_busy;
      logic back_busy;
      logic rotate_due;
   } tlqs_stat_type;

endpackage

// File: hw/rtl/tlqs_ram.sv
module tlqs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/tlqs_ctrl.sv
module tlqs_ctrl
   import tlqs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  tlqs_stat_type stat,
   output logic          busy,
   output tlqs_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECIDE,
      S_FETCH,
      S_HEAD
   } state_type;

   state_type state_ff, state_in;
   logic      rot_pending_ff, rot_pending_in;
   logic      busy_ff, busy_in;

   // Sequence one request: decide, and for a tick that serves a job read the queue head and act on it.
   always_comb begin
      state_in       = state_ff;
      rot_pending_in = rot_pending_ff;
      cmd            = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!stat.mode_tick) begin
               cmd.arrive = 1'b1;
               state_in   = S_IDLE;
            end else if (!stat.fore_busy && !stat.back_busy) begin
               cmd.idle_tick = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.read_head  = 1'b1;
               rot_pending_in = stat.rotate_due;
               state_in       = S_HEAD;
            end
         end
         S_HEAD: begin
            if (rot_pending_ff) begin
               cmd.rotate     = 1'b1;
               rot_pending_in = 1'b0;
               state_in       = S_FETCH;
            end else begin
               cmd.serve = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_FETCH: begin
            cmd.read_head = 1'b1;
            state_in      = S_HEAD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      busy_in = (state_in != S_IDLE);
   end

   // State and registered busy flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rot_pending_ff <= 1'b0;
         busy_ff        <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rot_pending_ff <= rot_pending_in;
         busy_ff        <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

// File: hw/rtl/tlqs_datapath.sv
module tlqs_datapath
   import tlqs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int BURST_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tlqs_cmd_type           cmd,
   output tlqs_stat_type          stat,
   input  logic                   req_mode,
   input  logic [ID_W-1:0]        req_job_id,
   input  logic [BURST_IN_W-1:0]  req_burst_length,
   input  logic [PRIO_W-1:0]      req_job_priority,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic                   rsp_valid,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [CLASS_W-1:0]     rsp_ran_class,
   output logic [ID_W-1:0]        rsp_ran_job,
   output logic                   rsp_job_finished,
   output logic [COUNT_OUT_W-1:0] rsp_fore_count,
   output logic [COUNT_OUT_W-1:0] rsp_back_count,
   output logic [CTR_W-1:0]       rsp_ticks_elapsed,
   output logic [CTR_W-1:0]       rsp_ticks_busy,
   output logic [CTR_W-1:0]       rsp_wait_total
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int ENT_W = ID_W + BURST_BITS;
   localparam logic [CNT_W-1:0] FILL_FULL = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W:0]   DEPTH_X   = (CNT_W + 1)'(QUEUE_DEPTH);
   localparam logic [32:0]      BURST_MAX = (33'd1 << BURST_BITS) - 33'd1;

   // Circular slot: base plus offset, wrapped once at the queue depth.
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
      if (sum >= DEPTH_X) begin
         sum = sum - DEPTH_X;
      end
      return sum[IDX_W-1:0];
   endfunction

   // Captured request.
   logic                  mode_ff;
   logic [ID_W-1:0]       id_ff;
   logic [BURST_IN_W-1:0] burst_ff;
   logic [PRIO_W-1:0]     prio_ff;

   // Configuration registers.
   logic [QUANTUM_W-1:0] quantum_ff;
   logic [PRIO_W-1:0]    limit_ff;

   // Queue pointers, phase and counters.
   logic [IDX_W-1:0] fore_head_ff, fore_head_in, back_head_ff, back_head_in;
   logic [CNT_W-1:0] fore_fill_ff, fore_fill_in, back_fill_ff, back_fill_in;
   logic [QUANTUM_W-1:0] phase_ff, phase_in;
   logic [CTR_W-1:0] elapsed_ff, elapsed_in, busy_cnt_ff, busy_cnt_in, wait_ff, wait_in;

   // Response registers.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [CLASS_W-1:0]  class_ff, class_in;
   logic [ID_W-1:0]     job_ff, job_in;
   logic                fin_ff, fin_in;

   // Queue memory ports.
   logic             fore_we, back_we;
   logic [IDX_W-1:0] fore_waddr, back_waddr;
   logic [ENT_W-1:0] fore_wdata, back_wdata, fore_rd, back_rd;

   // Decoded values.
   logic                  use_fore, goes_fore, finished;
   logic [ENT_W-1:0]      head_ent;
   logic [BURST_BITS-1:0] head_rem, rem_dec, burst_sat;
   logic [ID_W-1:0]       head_id;
   logic [32:0]           burst_ext, wait_sum;
   logic [CNT_W-1:0]      tgt_fill;
   logic [CNT_W:0]        wait_add;
   logic [QUANTUM_W:0]    quantum_eff, phase_plus;
   logic [QUANTUM_W-1:0]  phase_next;
   logic [CTR_W-1:0]      elapsed_next;

   tlqs_ram #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_fore_ram (
      .clock   (clock),
      .wr_en   (fore_we),
      .wr_addr (fore_waddr),
      .wr_data (fore_wdata),
      .rd_en   (cmd.read_head),
      .rd_addr (fore_head_ff),
      .rd_data (fore_rd)
   );

   tlqs_ram #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_back_ram (
      .clock   (clock),
      .wr_en   (back_we),
      .wr_addr (back_waddr),
      .wr_data (back_wdata),
      .rd_en   (cmd.read_head),
      .rd_addr (back_head_ff),
      .rd_data (back_rd)
   );

   // Shared decode of the captured request, the head entry and the tick math.
   always_comb begin
      use_fore  = (fore_fill_ff != '0);
      goes_fore = (prio_ff <= limit_ff);
      tgt_fill  = goes_fore ? fore_fill_ff : back_fill_ff;

      burst_ext = 33'(burst_ff);
      burst_sat = BURST_BITS'((burst_ext > BURST_MAX) ? BURST_MAX : burst_ext);

      head_ent = use_fore ? fore_rd : back_rd;
      head_rem = head_ent[BURST_BITS-1:0];
      head_id  = head_ent[ENT_W-1:BURST_BITS];
      rem_dec  = (head_rem == '0) ? '0 : head_rem - BURST_BITS'(1);
      finished = (rem_dec == '0);

      // Waiting jobs: everyone in line but the one that runs.
      if (use_fore) begin
         wait_add = (CNT_W + 1)'(fore_fill_ff) - (CNT_W + 1)'(1)
                    + (CNT_W + 1)'(back_fill_ff);
      end else begin
         wait_add = (CNT_W + 1)'(back_fill_ff) - (CNT_W + 1)'(1);
      end
      wait_sum = {1'b0, wait_ff} + 33'(wait_add);

      // A quantum of zero acts as one.
      quantum_eff  = (quantum_ff == '0) ? (QUANTUM_W + 1)'(1) : {1'b0, quantum_ff};
      phase_plus   = {1'b0, phase_ff} + (QUANTUM_W + 1)'(1);
      phase_next   = (phase_plus >= quantum_eff) ? '0 : phase_plus[QUANTUM_W-1:0];
      elapsed_next = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + CTR_W'(1);
   end

   // Next-state logic for every command.
   always_comb begin
      fore_head_in = fore_head_ff;
      back_head_in = back_head_ff;
      fore_fill_in = fore_fill_ff;
      back_fill_in = back_fill_ff;
      phase_in     = phase_ff;
      elapsed_in   = elapsed_ff;
      busy_cnt_in  = busy_cnt_ff;
      wait_in      = wait_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      class_in     = class_ff;
      job_in       = job_ff;
      fin_in       = fin_ff;
      fore_we      = 1'b0;
      back_we      = 1'b0;
      fore_waddr   = slot_of(fore_head_ff, fore_fill_ff);
      back_waddr   = slot_of(back_head_ff, back_fill_ff);
      fore_wdata   = {id_ff, burst_sat};
      back_wdata   = {id_ff, burst_sat};

      // Arrival: push onto the chosen queue unless dropped.
      if (cmd.arrive) begin
         rsp_valid_in = 1'b1;
         class_in     = CLS_IDLE;
         job_in       = '0;
         fin_in       = 1'b0;
         if (burst_sat == '0) begin
            status_in = ST_DROP_ZERO;
         end else if (tgt_fill >= FILL_FULL) begin
            status_in = ST_DROP_FULL;
         end else if (goes_fore) begin
            fore_we      = 1'b1;
            fore_fill_in = fore_fill_ff + CNT_W'(1);
            status_in    = ST_QUEUED_FORE;
         end else begin
            back_we      = 1'b1;
            back_fill_in = back_fill_ff + CNT_W'(1);
            status_in    = ST_QUEUED_BACK;
         end
      end

      // Tick with both queues empty.
      if (cmd.idle_tick) begin
         rsp_valid_in = 1'b1;
         status_in    = ST_TICK_DONE;
         class_in     = CLS_IDLE;
         job_in       = '0;
         fin_in       = 1'b0;
         elapsed_in   = elapsed_next;
         phase_in     = phase_next;
      end

      // Quantum expiry: copy the foreground head to the tail.
      if (cmd.rotate) begin
         fore_we      = 1'b1;
         fore_wdata   = fore_rd;
         fore_head_in = slot_of(fore_head_ff, CNT_W'(1));
      end

      // Serve the head for one tick; it leaves when its work is done.
      if (cmd.serve) begin
         rsp_valid_in = 1'b1;
         status_in    = ST_TICK_DONE;
         class_in     = use_fore ? CLS_FORE : CLS_BACK;
         job_in       = head_id;
         fin_in       = finished;
         elapsed_in   = elapsed_next;
         phase_in     = phase_next;
         busy_cnt_in  = (busy_cnt_ff == '1) ? busy_cnt_ff : busy_cnt_ff + CTR_W'(1);
         wait_in      = wait_sum[32] ? '1 : wait_sum[CTR_W-1:0];
         if (use_fore) begin
            fore_waddr = fore_head_ff;
            fore_wdata = {head_id, rem_dec};
            fore_we    = !finished;
            if (finished) begin
               fore_head_in = slot_of(fore_head_ff, CNT_W'(1));
               fore_fill_in = fore_fill_ff - CNT_W'(1);
            end
         end else begin
            back_waddr = back_head_ff;
            back_wdata = {head_id, rem_dec};
            back_we    = !finished;
            if (finished) begin
               back_head_in = slot_of(back_head_ff, CNT_W'(1));
               back_fill_in = back_fill_ff - CNT_W'(1);
            end
         end
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff   <= QUANTUM_RESET;
         limit_ff     <= FG_LIMIT_RESET;
         fore_head_ff <= '0;
         back_head_ff <= '0;
         fore_fill_ff <= '0;
         back_fill_ff <= '0;
         phase_ff     <= '0;
         elapsed_ff   <= '0;
         busy_cnt_ff  <= '0;
         wait_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_QUANTUM:  quantum_ff <= csr_data;
               CSR_FG_LIMIT: limit_ff   <= csr_data[PRIO_W-1:0];
               default: begin
               end
            endcase
         end
         fore_head_ff <= fore_head_in;
         back_head_ff <= back_head_in;
         fore_fill_ff <= fore_fill_in;
         back_fill_ff <= back_fill_in;
         phase_ff     <= phase_in;
         elapsed_ff   <= elapsed_in;
         busy_cnt_ff  <= busy_cnt_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         id_ff    <= req_job_id;
         burst_ff <= req_burst_length;
         prio_ff  <= req_job_priority;
      end
      status_ff <= status_in;
      class_ff  <= class_in;
      job_ff    <= job_in;
      fin_ff    <= fin_in;
   end

   // Status toward the controller.
   assign stat.mode_tick  = (mode_ff == MODE_TICK);
   assign stat.fore_busy  = use_fore;
   assign stat.back_busy  = (back_fill_ff != '0);
   assign stat.rotate_due = use_fore && (phase_ff == '0);

   // Counters and fills change only on the edge that raises the strobe.
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_ran_class     = class_ff;
   assign rsp_ran_job       = job_ff;
   assign rsp_job_finished  = fin_ff;
   assign rsp_fore_count    = COUNT_OUT_W'(fore_fill_ff);
   assign rsp_back_count    = COUNT_OUT_W'(back_fill_ff);
   assign rsp_ticks_elapsed = elapsed_ff;
   assign rsp_ticks_busy    = busy_cnt_ff;
   assign rsp_wait_total    = wait_ff;

endmodule

// File: hw/rtl/two_level_queue_scheduler_top.sv
// Two-class job scheduler with a round-robin foreground queue and a FIFO
// background queue, each held in a single-port-write, registered-read memory
// of QUEUE_DEPTH entries. A request is taken at a clock edge where start is
// high and busy is low. Exactly one response follows for every request, shown
// for a single cycle with rsp_valid high; the receiver cannot stall it, so it
// must capture the response in that cycle. An arrival or an idle tick is
// handled in the decide state alone. A tick that serves a job goes on to the
// head state, and one that also rotates the foreground head at a quantum
// boundary passes the head, fetch and head states in turn, because each head
// access is a read followed by a write-back through the registered memory
// port. The register port (csr_ready is always high) must be written only
// while the block is idle; an index outside the register list is ignored.
module two_level_queue_scheduler_top
   import tlqs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int BURST_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_mode,
   input  logic [ID_W-1:0]        req_job_id,
   input  logic [BURST_IN_W-1:0]  req_burst_length,
   input  logic [PRIO_W-1:0]      req_job_priority,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic                   rsp_valid,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [CLASS_W-1:0]     rsp_ran_class,
   output logic [ID_W-1:0]        rsp_ran_job,
   output logic                   rsp_job_finished,
   output logic [COUNT_OUT_W-1:0] rsp_fore_count,
   output logic [COUNT_OUT_W-1:0] rsp_back_count,
   output logic [CTR_W-1:0]       rsp_ticks_elapsed,
   output logic [CTR_W-1:0]       rsp_ticks_busy,
   output logic [CTR_W-1:0]       rsp_wait_total
);

   tlqs_cmd_type  cmd;
   tlqs_stat_type stat;

   // Sequencer for one request at a time.
   tlqs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   // Queues, counters and response registers.
   tlqs_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .BURST_BITS  (BURST_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_mode          (req_mode),
      .req_job_id        (req_job_id),
      .req_burst_length  (req_burst_length),
      .req_job_priority  (req_job_priority),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_ran_class     (rsp_ran_class),
      .rsp_ran_job       (rsp_ran_job),
      .rsp_job_finished  (rsp_job_finished),
      .rsp_fore_count    (rsp_fore_count),
      .rsp_back_count    (rsp_back_count),
      .rsp_ticks_elapsed (rsp_ticks_elapsed),
      .rsp_ticks_busy    (rsp_ticks_busy),
      .rsp_wait_total    (rsp_wait_total)
   );

endmodule

// File: hw/rtl/tlqs_checker.sv
module tlqs_checker
   import tlqs_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [CLASS_W-1:0]  rsp_ran_class,
   input logic [ID_W-1:0]     rsp_ran_job,
   input logic                rsp_job_finished
);

   // An accepted request always makes the block busy in the following cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // A response is issued only as the block returns to idle.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while busy");

   // Each request gives one single-cycle response.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held longer than one cycle");

   // Arrival responses carry no served job.
   a_arrival_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_TICK_DONE) |->
         (rsp_ran_class == CLS_IDLE && rsp_ran_job == '0 && !rsp_job_finished))
      else $error("arrival response reports a served job");

   // An idle tick serves nothing.
   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ran_class == CLS_IDLE) |->
         (rsp_ran_job == '0 && !rsp_job_finished))
      else $error("idle tick reports a served job");

endmodule

bind two_level_queue_scheduler_top tlqs_checker u_tlqs_checker (.*);

// File: verif/two_level_queue_scheduler_top_tb.sv
module two_level_queue_scheduler_top_tb;
   import tlqs_pkg::*;

   localparam int DEPTH       = 16;
   localparam int HEAD_W      = $clog2(DEPTH);
   localparam int STALL_LIMIT = 1000;
   localparam int RANDOM_ITEMS = 880;
   localparam int DIR_ROWS    = 18;

   // Queue selectors for the scheduler state arrays.
   localparam int QSEL_FORE = 0;
   localparam int QSEL_BACK = 1;

   // Settings walked by the random phases before they turn fully random.
   localparam logic [QUANTUM_W-1:0] QUANT_PICKS [6] = '{QUANTUM_RESET, 8'd1, 8'd255,
                                                      8'd0, 8'd3, 8'd2};
   localparam logic [PRIO_W-1:0] LIMIT_PICKS [6] = '{FG_LIMIT_RESET, 4'd15, 4'd0,
                                                   4'd7, 4'd8, 4'd1};
   localparam int ARRIVE_PCT [4] = '{25, 40, 55, 75};

   typedef struct packed {
      logic                  mode;
      logic [ID_W-1:0]       job_id;
      logic [BURST_IN_W-1:0] burst;
      logic [PRIO_W-1:0]     prio;
   } sched_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [CLASS_W-1:0]     ran_class;
      logic [ID_W-1:0]        ran_job;
      logic                   finished;
      logic [COUNT_OUT_W-1:0] fore_count;
      logic [COUNT_OUT_W-1:0] back_count;
      logic [CTR_W-1:0]       elapsed;
      logic [CTR_W-1:0]       busy_ticks;
      logic [CTR_W-1:0]       wait_total;
   } sched_rsp_type;

   // The part of a response that a directed row can state outright.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CLASS_W-1:0]  ran_class;
      logic [ID_W-1:0]     ran_job;
      logic                finished;
   } tick_outcome_type;

   typedef struct packed {
      sched_req_type    req;
      logic [4:0]       reps;
      logic             typed;
      tick_outcome_type outcome;
   } dir_row_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic                   req_mode;
   logic [ID_W-1:0]        req_job_id;
   logic [BURST_IN_W-1:0]  req_burst_length;
   logic [PRIO_W-1:0]      req_job_priority;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   logic                   rsp_valid;
   logic [STATUS_W-1:0]    rsp_status;
   logic [CLASS_W-1:0]     rsp_ran_class;
   logic [ID_W-1:0]        rsp_ran_job;
   logic                   rsp_job_finished;
   logic [COUNT_OUT_W-1:0] rsp_fore_count;
   logic [COUNT_OUT_W-1:0] rsp_back_count;
   logic [CTR_W-1:0]       rsp_ticks_elapsed;
   logic [CTR_W-1:0]       rsp_ticks_busy;
   logic [CTR_W-1:0]       rsp_wait_total;

   // Scheduler state as the testbench tracks it.
   logic [ID_W-1:0]        job_id_mem  [2][DEPTH];
   logic [BURST_IN_W-1:0]  job_rem_mem [2][DEPTH];
   logic [HEAD_W-1:0]      q_head [2];
   logic [COUNT_OUT_W-1:0] q_fill [2];
   logic [QUANTUM_W-1:0]   phase_cnt;
   logic [CTR_W-1:0]       elapsed_acc;
   logic [CTR_W-1:0]       busy_acc;
   logic [CTR_W-1:0]       wait_acc;
   logic [QUANTUM_W-1:0]   cfg_quantum;
   logic [PRIO_W-1:0]      cfg_fg_limit;

   sched_rsp_type pending_outcomes [$];
   dir_row_type   dir_table [DIR_ROWS];
   int            mismatch_count = 0;
   int            rsp_seen = 0;
   int            stall_cycles = 0;

   two_level_queue_scheduler_top #(
      .QUEUE_DEPTH (DEPTH),
      .BURST_BITS  (BURST_IN_W)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_job_id        (req_job_id),
      .req_burst_length  (req_burst_length),
      .req_job_priority  (req_job_priority),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_ran_class     (rsp_ran_class),
      .rsp_ran_job       (rsp_ran_job),
      .rsp_job_finished  (rsp_job_finished),
      .rsp_fore_count    (rsp_fore_count),
      .rsp_back_count    (rsp_back_count),
      .rsp_ticks_elapsed (rsp_ticks_elapsed),
      .rsp_ticks_busy    (rsp_ticks_busy),
      .rsp_wait_total    (rsp_wait_total)
   );

   // Free-running clock, period 12.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic logic [CTR_W-1:0] sat_add(logic [CTR_W-1:0] a, logic [CTR_W-1:0] b);
      logic [CTR_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[CTR_W] ? '1 : sum[CTR_W-1:0];
   endfunction

   function automatic int slot_of(int base, int offset);
      return (base + offset) % DEPTH;
   endfunction

   function automatic void reset_schedule();
      for (int c = 0; c < 2; c++) begin
         q_head[c] = '0;
         q_fill[c] = '0;
         for (int i = 0; i < DEPTH; i++) begin
            job_id_mem[c][i]  = '0;
            job_rem_mem[c][i] = '0;
         end
      end
      phase_cnt    = '0;
      elapsed_acc  = '0;
      busy_acc     = '0;
      wait_acc     = '0;
      cfg_quantum  = QUANTUM_RESET;
      cfg_fg_limit = FG_LIMIT_RESET;
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_QUANTUM:  cfg_quantum = data;
         CSR_FG_LIMIT: cfg_fg_limit = data[PRIO_W-1:0];
         default: ;
      endcase
   endfunction

   // Moves the head job of a queue to its tail.
   function automatic void rotate_head(int c);
      int h;
      int t;
      h = q_head[c];
      t = slot_of(h, q_fill[c]);
      job_id_mem[c][t]  = job_id_mem[c][h];
      job_rem_mem[c][t] = job_rem_mem[c][h];
      q_head[c] = HEAD_W'(slot_of(h, 1));
   endfunction

   // Runs the head job of a queue for one tick; a job that is done leaves.
   function automatic logic serve_head(int c, output logic [ID_W-1:0] who);
      int h;
      h = q_head[c];
      who = job_id_mem[c][h];
      if (job_rem_mem[c][h] != '0)
         job_rem_mem[c][h] = job_rem_mem[c][h] - 1'b1;
      if (job_rem_mem[c][h] == '0) begin
         q_head[c] = HEAD_W'(slot_of(h, 1));
         q_fill[c] = q_fill[c] - 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Applies one request to the tracked state and returns the response it causes.
   function automatic sched_rsp_type schedule_step(sched_req_type r);
      sched_rsp_type o;
      int c;
      int t;
      logic [QUANTUM_W-1:0] eff_quantum;
      logic [ID_W-1:0] who;
      o = '0;
      if (r.mode == MODE_ARRIVE) begin
         c = (r.prio <= cfg_fg_limit) ? QSEL_FORE : QSEL_BACK;
         if (r.burst == '0) begin
            o.status = ST_DROP_ZERO;
         end else if (q_fill[c] >= DEPTH) begin
            o.status = ST_DROP_FULL;
         end else begin
            t = slot_of(q_head[c], q_fill[c]);
            job_id_mem[c][t]  = r.job_id;
            job_rem_mem[c][t] = r.burst;
            q_fill[c] = q_fill[c] + 1'b1;
            o.status = (c == QSEL_FORE) ? ST_QUEUED_FORE : ST_QUEUED_BACK;
         end
      end else begin
         // A zero quantum acts as a quantum of one.
         eff_quantum = (cfg_quantum == '0) ? 8'd1 : cfg_quantum;
         o.status = ST_TICK_DONE;
         o.ran_class = CLS_IDLE;
         if (q_fill[QSEL_FORE] != '0) begin
            if (phase_cnt == '0)
               rotate_head(QSEL_FORE);
            wait_acc = sat_add(wait_acc, CTR_W'(q_fill[QSEL_FORE]) - 1
                               + CTR_W'(q_fill[QSEL_BACK]));
            o.finished  = serve_head(QSEL_FORE, who);
            o.ran_job   = who;
            o.ran_class = CLS_FORE;
         end else if (q_fill[QSEL_BACK] != '0) begin
            wait_acc = sat_add(wait_acc, CTR_W'(q_fill[QSEL_BACK]) - 1);
            o.finished  = serve_head(QSEL_BACK, who);
            o.ran_job   = who;
            o.ran_class = CLS_BACK;
         end
         if (o.ran_class != CLS_IDLE)
            busy_acc = sat_add(busy_acc, 1);
         elapsed_acc = sat_add(elapsed_acc, 1);
         // The phase follows the global tick count, idle ticks included.
         phase_cnt = (int'(phase_cnt) + 1 >= int'(eff_quantum)) ? '0 : phase_cnt + 1'b1;
      end
      o.fore_count = q_fill[QSEL_FORE];
      o.back_count = q_fill[QSEL_BACK];
      o.elapsed    = elapsed_acc;
      o.busy_ticks = busy_acc;
      o.wait_total = wait_acc;
      return o;
   endfunction

   function automatic sched_req_type random_request(int arrive_pct);
      sched_req_type r;
      int c;
      int pick;
      r.mode   = ($urandom_range(0, 99) < arrive_pct) ? MODE_ARRIVE : MODE_TICK;
      r.job_id = ID_W'($urandom);
      r.prio   = PRIO_W'($urandom);
      c = (r.prio <= cfg_fg_limit) ? QSEL_FORE : QSEL_BACK;
      pick = $urandom_range(0, 99);
      // Short bursts keep jobs moving; wide bursts only go to a full queue.
      if (r.mode == MODE_TICK)
         r.burst = BURST_IN_W'($urandom);
      else if (pick < 6)
         r.burst = '0;
      else if (q_fill[c] >= DEPTH)
         r.burst = BURST_IN_W'($urandom_range(1, 65535));
      else if (pick < 82)
         r.burst = BURST_IN_W'($urandom_range(1, 6));
      else
         r.burst = BURST_IN_W'($urandom_range(7, 40));
      return r;
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [CTR_W-1:0] got,
                              input logic [CTR_W-1:0] want);
      if (got !== want)
         flag_mismatch($sformatf("response %0d %s got %0h expected %0h",
                                 rsp_seen, name, got, want));
   endtask

   // Issues one request after a gap and records its outcome when it is taken.
   // Start stays high on return so that a back-to-back request keeps it high.
   task automatic send_request(input sched_req_type r, input int gap,
                               input logic typed = 1'b0,
                               input tick_outcome_type typed_out = '0);
      sched_rsp_type want;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_mode         <= r.mode;
      req_job_id       <= r.job_id;
      req_burst_length <= r.burst;
      req_job_priority <= r.prio;
      do @(posedge clock); while (busy !== 1'b0);
      want = schedule_step(r);
      if (typed) begin
         want.status    = typed_out.status;
         want.ran_class = typed_out.ran_class;
         want.ran_job   = typed_out.ran_job;
         want.finished  = typed_out.finished;
      end
      pending_outcomes = {pending_outcomes, want};
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      apply_csr(idx, data);
   endtask

   // Writes both registers, sometimes after a write to an unused index.
   task automatic load_settings(input logic [QUANTUM_W-1:0] quantum,
                                input logic [PRIO_W-1:0] limit);
      if ($urandom_range(0, 3) == 0)
         write_csr(CSR_FG_LIMIT + CSR_IDX_W'($urandom_range(1, 2)), CSR_DATA_W'($urandom));
      write_csr(CSR_QUANTUM, quantum);
      write_csr(CSR_FG_LIMIT, {4'($urandom), limit});
      csr_valid <= 1'b0;
   endtask

   // Holds off new requests until every response is in and the block is idle.
   task automatic wait_quiet();
      start <= 1'b0;
      while (pending_outcomes.size() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Compare every response with the oldest outstanding outcome.
   always @(posedge clock) begin : rsp_check
      sched_rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            flag_mismatch($sformatf("response %0d arrived with no request outstanding",
                                    rsp_seen));
         end else begin
            want = pending_outcomes.pop_front();
            check_field("status", CTR_W'(rsp_status), CTR_W'(want.status));
            check_field("ran_class", CTR_W'(rsp_ran_class), CTR_W'(want.ran_class));
            check_field("ran_job", CTR_W'(rsp_ran_job), CTR_W'(want.ran_job));
            check_field("job_finished", CTR_W'(rsp_job_finished), CTR_W'(want.finished));
            check_field("fore_count", CTR_W'(rsp_fore_count), CTR_W'(want.fore_count));
            check_field("back_count", CTR_W'(rsp_back_count), CTR_W'(want.back_count));
            check_field("ticks_elapsed", rsp_ticks_elapsed, want.elapsed);
            check_field("ticks_busy", rsp_ticks_busy, want.busy_ticks);
            check_field("wait_total", rsp_wait_total, want.wait_total);
         end
         rsp_seen++;
      end
   end

   // End the run when nothing moves on any port for too long.
   always @(posedge clock) begin
      if (reset || (start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1
          || (csr_valid === 1'b1 && csr_ready === 1'b1)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      sched_req_type r;
      int sent;
      int phase_idx;
      int arrive_pct;
      int max_gap;
      int len;

      start            <= 1'b0;
      req_mode         <= MODE_ARRIVE;
      req_job_id       <= '0;
      req_burst_length <= '0;
      req_job_priority <= '0;
      csr_valid        <= 1'b0;
      csr_index        <= CSR_QUANTUM;
      csr_data         <= '0;
      reset            <= 1'b1;
      reset_schedule();

      // Directed requests under the reset settings. Typed rows state the
      // outcome outright; the rest rely on the tracked state.
      dir_table = '{
         // Idle tick right after reset, arrival fields at their top values.
         '{'{MODE_TICK,   8'hFF, 16'hFFFF, 4'hF}, 5'd1, 1'b1,
           '{ST_TICK_DONE, CLS_IDLE, 8'h00, 1'b0}},
         '{'{MODE_ARRIVE, 8'hFF, 16'h0000, 4'h0}, 5'd1, 1'b1,
           '{ST_DROP_ZERO, CLS_IDLE, 8'h00, 1'b0}},
         '{'{MODE_ARRIVE, 8'h00, 16'h0001, 4'h0}, 5'd1, 1'b1,
           '{ST_QUEUED_FORE, CLS_IDLE, 8'h00, 1'b0}},
         // Priority equal to the limit still goes to the foreground.
         '{'{MODE_ARRIVE, 8'h80, 16'h0003, 4'h2}, 5'd1, 1'b1,
           '{ST_QUEUED_FORE, CLS_IDLE, 8'h00, 1'b0}},
         '{'{MODE_ARRIVE, 8'h7F, 16'h0002, 4'h3}, 5'd1, 1'b1,
           '{ST_QUEUED_BACK, CLS_IDLE, 8'h00, 1'b0}},
         '{'{MODE_ARRIVE, 8'h55, 16'h0001, 4'hF}, 5'd1, 1'b1,
           '{ST_QUEUED_BACK, CLS_IDLE, 8'h00, 1'b0}},
         '{'{MODE_TICK,   8'h00, 16'h0000, 4'h0}, 5'd1, 1'b1,
           '{ST_TICK_DONE, CLS_FORE, 8'h00, 1'b1}},
         '{'{MODE_TICK,   8'h00, 16'h0000, 4'h0}, 5'd1, 1'b1,
           '{ST_TICK_DONE, CLS_FORE, 8'h80, 1'b0}},
         '{'{MODE_TICK,   8'h00, 16'h0000, 4'h0}, 5'd1, 1'b1,
           '{ST_TICK_DONE, CLS_FORE, 8'h80, 1'b0}},
         '{'{MODE_TICK,   8'h00, 16'h0000, 4'h0}, 5'd1, 1'b1,
           '{ST_TICK_DONE, CLS_FORE, 8'h80, 1'b1}},
         // Foreground empty, so the background head runs.
         '{'{MODE_TICK,   8'h00, 16'h0000, 4'h0}, 5'd1, 1'b1,
           '{ST_TICK_DONE, CLS_BACK, 8'h7F, 1'b0}},
         // Two foreground jobs long enough to see a rotation at the quantum.
         '{'{MODE_ARRIVE, 8'h01, 16'h0006, 4'h1}, 5'd1, 1'b0, '0},
         '{'{MODE_ARRIVE, 8'h02, 16'h0003, 4'h0}, 5'd1, 1'b0, '0},
         '{'{MODE_TICK,   8'h00, 16'h0000, 4'h0}, 5'd8, 1'b0, '0},
         // Fill the background queue until arrivals start to drop.
         '{'{MODE_ARRIVE, 8'h20, 16'h0001, 4'hF}, 5'd16, 1'b0, '0},
         '{'{MODE_ARRIVE, 8'hFF, 16'hFFFF, 4'hF}, 5'd1, 1'b1,
           '{ST_DROP_FULL, CLS_IDLE, 8'h00, 1'b0}},
         '{'{MODE_ARRIVE, 8'h00, 16'hFFFF, 4'h9}, 5'd1, 1'b1,
           '{ST_DROP_FULL, CLS_IDLE, 8'h00, 1'b0}},
         '{'{MODE_TICK,   8'h00, 16'h0000, 4'h0}, 5'd4, 1'b0, '0}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         for (int k = 0; k < int'(dir_table[i].reps); k++) begin
            r = dir_table[i].req;
            if (r.mode == MODE_ARRIVE)
               r.job_id = r.job_id + ID_W'(k);
            send_request(r, $urandom_range(0, 7), dir_table[i].typed, dir_table[i].outcome);
         end
      end

      // Random phases, each under its own settings and request mix.
      sent = 0;
      phase_idx = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_quiet();
         if (phase_idx < 6)
            load_settings(QUANT_PICKS[phase_idx], LIMIT_PICKS[phase_idx]);
         else
            load_settings(QUANTUM_W'($urandom_range(0, 255)), PRIO_W'($urandom_range(0, 15)));
         arrive_pct = ARRIVE_PCT[$urandom_range(0, 3)];
         max_gap = ($urandom_range(0, 3) == 0) ? 0 : 7;
         len = $urandom_range(20, 70);
         repeat (len) begin
            send_request(random_request(arrive_pct), $urandom_range(0, max_gap));
            sent++;
         end
         phase_idx++;
      end

      wait_quiet();
      if (pending_outcomes.size() != 0)
         flag_mismatch($sformatf("%0d responses never arrived", pending_outcomes.size()));
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
